@@ hdl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// lps_pkg
// shared widths, constants and types of the linear prime sieve
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int LIMIT_W  = 17;
    localparam int NUMBER_W = 16;
    localparam int COUNT_W  = 14;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 17'd65536;
    localparam logic [LIMIT_W-1:0] LIMIT_MIN    = 17'd3;
    localparam int                 FIRST_NUMBER = 2;

    // status of the iterative remainder unit
    typedef struct packed {
        logic busy;
        logic done;
        logic divides;
    } lps_mod_status_t;

endpackage

@@ hdl/lps_if.sv @@
// ----------------------------------------------------------------------------
// lps channel interfaces
// tick requests, per-tick results and the limit write channel
// ----------------------------------------------------------------------------
interface lps_req_if;
    import lps_pkg::*;

    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface lps_res_if;
    import lps_pkg::*;

    logic                valid;
    logic                ready;
    logic [NUMBER_W-1:0] number;
    logic                is_prime;
    logic [COUNT_W-1:0]  prime_count;
    logic                finished;

    modport source (output valid, output number, output is_prime, output prime_count,
                    output finished, input ready);
    modport sink   (input valid, input number, input is_prime, input prime_count,
                    input finished, output ready);
endinterface

interface lps_cfg_if;
    import lps_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] limit;

    modport source (output valid, output limit, input ready);
    modport sink   (input valid, input limit, output ready);
endinterface

@@ hdl/lps_ram.sv @@
// ----------------------------------------------------------------------------
// lps_ram
// simple dual-port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/lps_mod_unit.sv @@
// ----------------------------------------------------------------------------
// lps_mod_unit
// restoring remainder unit, one dividend bit per cycle, flags exact division
// ----------------------------------------------------------------------------
module lps_mod_unit #(
    parameter int W = 17
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [W-1:0]             dividend,
    input  logic [W-1:0]             divisor,
    output lps_pkg::lps_mod_status_t status
);
    import lps_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W:0]       trial;
    logic [W:0]       diff;

    assign trial = {rem_reg, dvd_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[W-1:0];
            end
            else
            begin
                rem_next = trial[W-1:0];
            end
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy    = busy_reg;
    assign status.done    = done_reg;
    assign status.divides = (rem_reg == '0);

endmodule

@@ hdl/linear_prime_sieve_top.sv @@
// ----------------------------------------------------------------------------
// linear_prime_sieve_top
// Linear (Euler) sieve stepped one number per request transfer. Each request
// examines the current number (2 after reset or restart): an unmarked number
// is prime and joins the prime list if it has room, then the number times
// each stored prime is marked composite in order while the product stays
// below the limit, stopping after the prime that divides the number. Every
// request gives exactly one result transfer with the number, its primality,
// the running prime count and a finished flag; once the number reaches the
// limit the state holds and finished results are returned. Once a request
// is taken the sequencer reads the mark of the number, then for each stored
// prime it reads the list, forms the product and compares it with the limit;
// below the limit it marks the product and runs the bit-serial remainder
// unit until it is done. The walk ends when it runs out of stored primes,
// when the product reaches the limit or when the prime divides the number.
// The sequencer then loads the result register, waiting first, if need be,
// for the previous result to be taken. After reset the block runs a
// clearing pass over all SIEVE_SIZE marks, one mark a cycle, before it
// takes the first request; a restart clears the marks up to the highest
// one written since the last clearing pass in the same way. The limit
// register may be written at any time through the configuration channel.
// ----------------------------------------------------------------------------
module linear_prime_sieve_top #(
    parameter int SIEVE_SIZE     = 65536,
    parameter int PRIME_CAPACITY = 8192
) (
    input  logic         clk,
    input  logic         rst_n,
    lps_req_if.sink      req,
    lps_res_if.source    res,
    lps_cfg_if.sink      cfg
);
    import lps_pkg::*;

    // number width holds SIEVE_SIZE itself, mark address one bit less
    localparam int NW  = $clog2(SIEVE_SIZE) + 1;
    localparam int AW  = $clog2(SIEVE_SIZE);
    localparam int CW  = $clog2(PRIME_CAPACITY + 1);
    localparam int PAW = $clog2(PRIME_CAPACITY);
    localparam int PW  = AW + NW;
    localparam int LW  = (NW > LIMIT_W) ? NW : LIMIT_W;

    // sequencer states
    localparam logic [3:0] S_SWEEP = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_MARK  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_LOAD  = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg;
    logic [NW-1:0]      cur_reg, cur_next;
    logic [NW-1:0]      n_reg, n_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [AW-1:0]      p_reg, p_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic               prime_reg, prime_next;
    logic               fin_reg, fin_next;
    logic [NW-1:0]      dirty_reg, dirty_next;   // one past the highest mark written
    logic [NW-1:0]      clr_reg, clr_next;
    logic               after_reg, after_next;   // sweep was caused by a restart

    // result register, parts the sequencer from the result channel
    logic                res_valid_reg, res_valid_next;
    logic [NUMBER_W-1:0] res_number_reg, res_number_next;
    logic                res_prime_reg, res_prime_next;
    logic [COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                res_fin_reg, res_fin_next;

    logic [LW-1:0] lim_ext;
    logic [NW-1:0] lim;

    // mark store ports
    logic          mark_we;
    logic [AW-1:0] mark_waddr;
    logic          mark_wdata;
    logic          mark_rdata;

    // prime list ports
    logic           plist_we;
    logic [PAW-1:0] plist_waddr;
    logic [AW-1:0]  plist_rdata;

    logic            mod_start;
    lps_mod_status_t mod_status;

    logic req_xfer;
    logic res_free;

    // effective limit: raised to the minimum and cut to the sieve size
    assign lim_ext = LW'(limit_reg);

    always_comb
    begin
        priority if (lim_ext < LW'(LIMIT_MIN))
        begin
            lim = NW'(LIMIT_MIN);
        end
        else if (lim_ext > LW'(SIEVE_SIZE))
        begin
            lim = NW'(SIEVE_SIZE);
        end
        else
        begin
            lim = NW'(lim_ext);
        end
    end

    // configuration: always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.limit;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign res_free  = !res_valid_reg || res.ready;

    // mark store, one bit per number
    lps_ram #(
        .WIDTH (1),
        .DEPTH (SIEVE_SIZE)
    ) u_marks (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (cur_reg[AW-1:0]),
        .rdata (mark_rdata)
    );

    // prime list, entries below the count are always written before read
    lps_ram #(
        .WIDTH (AW),
        .DEPTH (PRIME_CAPACITY)
    ) u_primes (
        .clk   (clk),
        .we    (plist_we),
        .waddr (plist_waddr),
        .wdata (n_reg[AW-1:0]),
        .raddr (j_reg[PAW-1:0]),
        .rdata (plist_rdata)
    );

    // divisibility of the number by the current prime
    lps_mod_unit #(
        .W (NW)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (n_reg),
        .divisor  (NW'(p_reg)),
        .status   (mod_status)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        n_next      = n_reg;
        count_next  = count_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        prod_next   = prod_reg;
        prime_next  = prime_reg;
        fin_next    = fin_reg;
        dirty_next  = dirty_reg;
        clr_next    = clr_reg;
        after_next  = after_reg;
        mark_we     = 1'b0;
        mark_waddr  = prod_reg[AW-1:0];
        mark_wdata  = 1'b1;
        plist_we    = 1'b0;
        plist_waddr = count_reg[PAW-1:0];
        mod_start   = 1'b0;

        res_valid_next  = res_valid_reg && !res.ready;
        res_number_next = res_number_reg;
        res_prime_next  = res_prime_reg;
        res_count_next  = res_count_reg;
        res_fin_next    = res_fin_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                // clear one mark a cycle up to the dirty top
                mark_we    = 1'b1;
                mark_waddr = clr_reg[AW-1:0];
                mark_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_next >= dirty_reg)
                begin
                    dirty_next = '0;
                    clr_next   = '0;
                    state_next = after_reg ? S_CHECK : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req.restart)
                    begin
                        cur_next   = NW'(FIRST_NUMBER);
                        count_next = '0;
                        if (dirty_reg != '0)
                        begin
                            after_next = 1'b1;
                            state_next = S_SWEEP;
                        end
                        else
                        begin
                            state_next = S_CHECK;
                        end
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                // mark read of the current number is issued this cycle
                n_next     = cur_reg;
                prime_next = 1'b0;
                if (cur_reg >= lim)
                begin
                    fin_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    fin_next   = 1'b0;
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                prime_next = !mark_rdata;
                cur_next   = n_reg + 1'b1;
                j_next     = '0;
                if (!mark_rdata && (count_reg < CW'(PRIME_CAPACITY)))
                begin
                    plist_we   = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                state_next = S_WALK;
            end
            S_WALK:
            begin
                // list read at j is issued this cycle
                if (j_reg >= count_reg)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                p_next     = plist_rdata;
                prod_next  = PW'(plist_rdata) * PW'(n_reg);
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (prod_reg >= PW'(lim))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    mark_we   = 1'b1;
                    mod_start = 1'b1;
                    if (NW'(prod_reg) >= dirty_reg)
                    begin
                        dirty_next = NW'(prod_reg) + 1'b1;
                    end
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (mod_status.done)
                begin
                    if (mod_status.divides)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_EMIT:
            begin
                // wait for the result register to drain
                if (res_free)
                begin
                    res_valid_next  = 1'b1;
                    res_number_next = fin_reg ? '0 : NUMBER_W'(n_reg);
                    res_prime_next  = prime_reg;
                    res_count_next  = COUNT_W'(count_reg);
                    res_fin_next    = fin_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            cur_reg       <= NW'(FIRST_NUMBER);
            count_reg     <= '0;
            dirty_reg     <= NW'(SIEVE_SIZE);
            clr_reg       <= '0;
            after_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            count_reg     <= count_next;
            dirty_reg     <= dirty_next;
            clr_reg       <= clr_next;
            after_reg     <= (state_reg == S_SWEEP) ? after_reg && (state_next == S_SWEEP)
                                                    : after_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        j_reg          <= j_next;
        p_reg          <= p_next;
        prod_reg       <= prod_next;
        prime_reg      <= prime_next;
        fin_reg        <= fin_next;
        res_number_reg <= res_number_next;
        res_prime_reg  <= res_prime_next;
        res_count_reg  <= res_count_next;
        res_fin_reg    <= res_fin_next;
    end

    assign res.valid       = res_valid_reg;
    assign res.number      = res_number_reg;
    assign res.is_prime    = res_prime_reg;
    assign res.prime_count = res_count_reg;
    assign res.finished    = res_fin_reg;

endmodule

@@ test/tb_linear_prime_sieve_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_prime_sieve_top
// Steps the sieve one tick per request transfer and predicts every report
// with a model of the sieve kept in the bench. Directed runs cover the
// limit floor and ceiling, runs to finished and a limit raised mid-run,
// then random phases mix restarts, limits and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_linear_prime_sieve_top;
    import lps_pkg::*;

    localparam int SIEVE_SIZE      = 65536;
    localparam int PRIME_CAPACITY  = 8192;
    localparam int TICK_TARGET     = 600;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 200;
    // reset clearing pass is the longest quiet stretch (one mark a cycle)
    localparam int WATCHDOG_CYCLES = 400000;

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic                is_prime;
        logic [COUNT_W-1:0]  prime_count;
        logic                finished;
    } sieve_report_t;

    logic clk = 1'b0;
    logic rst_n;

    lps_req_if req_ch ();
    lps_res_if res_ch ();
    lps_cfg_if cfg_ch ();

    linear_prime_sieve_top #(
        .SIEVE_SIZE     (SIEVE_SIZE),
        .PRIME_CAPACITY (PRIME_CAPACITY)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always #2 clk = ~clk;

    // sieve state as the bench sees it
    bit                 composite [0:SIEVE_SIZE-1];
    int unsigned        found_primes [0:PRIME_CAPACITY-1];
    int unsigned        cur_number;
    int unsigned        prime_total;
    logic [LIMIT_W-1:0] limit_reg;
    int unsigned        top_mark;      // highest mark set since the last clear

    sieve_report_t owed_reports [$];
    int            mismatches = 0;
    int            ticks_sent = 0;
    bit            gaps_on;
    int            hold_req;

    // ------------------------------------------------------------------------
    // sieve prediction
    // ------------------------------------------------------------------------
    function automatic void clear_sieve();
        int unsigned i;
        for (i = 0; i <= top_mark; i++)
            composite[i] = 1'b0;
        top_mark    = 0;
        cur_number  = FIRST_NUMBER;
        prime_total = 0;
    endfunction

    // one tick of the linear sieve: every composite is marked once, by its
    // smallest prime factor
    function automatic sieve_report_t euler_tick(input bit restart);
        sieve_report_t   rep;
        int unsigned     lim;
        int unsigned     n;
        int unsigned     j;
        bit              prime;
        bit              walking;
        longint unsigned prod;

        if (restart)
            clear_sieve();

        // effective limit is clamped into [LIMIT_MIN, SIEVE_SIZE]
        lim = limit_reg;
        if (lim < LIMIT_MIN)
            lim = LIMIT_MIN;
        if (lim > SIEVE_SIZE)
            lim = SIEVE_SIZE;

        if (cur_number >= lim)
        begin
            rep.number      = '0;
            rep.is_prime    = 1'b0;
            rep.prime_count = COUNT_W'(prime_total);
            rep.finished    = 1'b1;
            return rep;
        end

        n     = cur_number;
        prime = !composite[n];
        // a full prime list still reports the prime but stores nothing
        if (prime && prime_total < PRIME_CAPACITY)
        begin
            found_primes[prime_total] = n;
            prime_total++;
        end

        walking = 1'b1;
        for (j = 0; j < prime_total && walking; j++)
        begin
            prod = longint'(found_primes[j]) * longint'(n);
            if (prod >= lim)
                walking = 1'b0;
            else
            begin
                composite[prod] = 1'b1;
                if (prod > top_mark)
                    top_mark = int'(prod);
                if (found_primes[j] == 0 || n % found_primes[j] == 0)
                    walking = 1'b0;
            end
        end

        cur_number = n + 1;

        rep.number      = NUMBER_W'(n);
        rep.is_prime    = prime;
        rep.prime_count = COUNT_W'(prime_total);
        rep.finished    = 1'b0;
        return rep;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // channel tasks
    // ------------------------------------------------------------------------
    // valid stays high after the transfer so back-to-back ticks need no
    // second assignment in the same step; end_burst drops it
    task automatic send_tick(input bit restart);
        int            gap;
        sieve_report_t rep;
        gap = gaps_on ? idle_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        rep = euler_tick(restart);
        owed_reports.insert(owed_reports.size(), rep);
        ticks_sent++;
    endtask

    task automatic end_burst();
        req_ch.valid <= 1'b0;
    endtask

    task automatic wait_reports();
        while (owed_reports.size() != 0)
            @(posedge clk);
    endtask

    // only called with the sieve idle, never twice in one step
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.limit <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        limit_reg = value;
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------
    // reset value of the limit, first tick straight after the clearing pass
    task automatic test_reset_limit();
        send_tick(1'b0);
        repeat (5) send_tick(1'b0);
        end_burst();
        wait_reports();
    endtask

    // limits under the floor act as the floor: 2 is sieved, then finished
    task automatic test_limit_floor();
        write_limit('0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        end_burst();
        wait_reports();
        write_limit(LIMIT_W'(2));
        send_tick(1'b1);
        send_tick(1'b0);
        end_burst();
        wait_reports();
    endtask

    // all ones in the register is cut to the sieve size
    task automatic test_limit_ceiling();
        write_limit('1);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        end_burst();
        wait_reports();
    endtask

    // run to finished, then raise the limit without a restart: the number
    // at the old limit was never marked and shows up as prime
    task automatic test_finish_then_raise();
        write_limit(LIMIT_W'(10));
        send_tick(1'b1);
        repeat (8) send_tick(1'b0);
        end_burst();
        wait_reports();
        write_limit(LIMIT_W'(16));
        repeat (3) send_tick(1'b0);
        end_burst();
        wait_reports();
    endtask

    // result side held off while ticks keep coming, so the input stalls
    task automatic test_result_holdoff();
        gaps_on  <= 1'b0;
        hold_req <= hold_req + 1;
        write_limit(LIMIT_W'(300));
        send_tick(1'b1);
        repeat (39) send_tick(1'b0);
        end_burst();
        wait_reports();
    endtask

    // random phases: a limit, then a burst of ticks, mostly well-formed runs
    task automatic test_random_phases();
        int                 k;
        int                 burst;
        int                 r;
        bit                 wide;
        bit                 restart;
        logic [LIMIT_W-1:0] value;

        while (ticks_sent < TICK_TARGET)
        begin
            gaps_on <= ($urandom_range(0, 3) != 0);
            r    = $urandom_range(0, 99);
            wide = 1'b0;
            if (r < 6)
                value = LIMIT_W'($urandom_range(0, 2));
            else if (r < 12)
            begin
                // wide limits always restart so marks stay low and restarts cheap
                value = LIMIT_W'($urandom_range(65536, 131071));
                wide  = 1'b1;
            end
            else
                value = LIMIT_W'($urandom_range(3, 400));
            write_limit(value);

            burst = wide ? $urandom_range(3, 20) : $urandom_range(4, 40);
            for (k = 0; k < burst; k++)
            begin
                if (k == 0)
                    restart = wide || ($urandom_range(0, 99) < 40);
                else
                    restart = ($urandom_range(0, 99) < 3);
                send_tick(restart);
            end
            end_burst();
            wait_reports();
        end
    endtask

    // ------------------------------------------------------------------------
    // result sink: random ready gaps, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int gap;
        int hold_seen;
        hold_seen = 0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                gap       = HOLD_CYCLES;
            end
            else
                gap = gaps_on ? idle_gap() : 0;
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // report check against the oldest owed report
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : report_check
        sieve_report_t got;
        sieve_report_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            got.number      = res_ch.number;
            got.is_prime    = res_ch.is_prime;
            got.prime_count = res_ch.prime_count;
            got.finished    = res_ch.finished;
            if (owed_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected report: number %0d is_prime %0b count %0d finished %0b",
                             got.number, got.is_prime, got.prime_count, got.finished);
            end
            else
            begin
                want = owed_reports.pop_front();
                if (got.number !== want.number || got.is_prime !== want.is_prime ||
                    got.prime_count !== want.prime_count || got.finished !== want.finished)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("report mismatch: expected number %0d is_prime %0b",
                                 want.number, want.is_prime);
                        $display("  count %0d finished %0b, got number %0d is_prime %0b",
                                 want.prime_count, want.finished, got.number, got.is_prime);
                        $display("  count %0d finished %0b",
                                 got.prime_count, got.finished);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles in a row with no transfer on any channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (rst_n !== 1'b1 ||
            (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_CYCLES)
        begin
            $display("linear_prime_sieve_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.restart <= 1'b0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.limit   <= '0;
        gaps_on        <= 1'b1;
        hold_req       <= 0;

        // bench state after reset: no marks, count zero, limit at reset value
        for (int i = 0; i < SIEVE_SIZE; i++)
            composite[i] = 1'b0;
        for (int i = 0; i < PRIME_CAPACITY; i++)
            found_primes[i] = 0;
        top_mark  = 0;
        limit_reg = LIMIT_RESET;
        clear_sieve();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_limit();
        test_limit_floor();
        test_limit_ceiling();
        test_finish_then_raise();
        test_result_holdoff();
        test_random_phases();

        // let any stray report surface before the verdict
        wait_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && owed_reports.size() == 0)
            $display("linear_prime_sieve_top test passed");
        else
            $display("linear_prime_sieve_top test failed");
        $finish;
    end

endmodule
